### rtl/bpa_pkg.sv
package bpa_pkg;

    // bitmap word width; one word covers 64 pages
    localparam int WORD_W = 64;
    localparam int WBIT_W = 6;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SEARCH,
        ST_FCHK,
        ST_FLEN,
        ST_RMW_RD,
        ST_RMW_WR,
        ST_LENW,
        ST_RESULT
    } state_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_NO_RUN   = 2'd1,
        STAT_BAD_FREE = 2'd2,
        STAT_ZERO_CNT = 2'd3
    } status_t;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic CFG_POOL_BASE    = 1'b0;
    localparam logic CFG_PAGES_IN_USE = 1'b1;

    // per-word summary produced by the scan stage
    typedef struct packed {
        logic              valid;
        logic [WORD_W-1:0] inner;    // free runs >= count ending at each bit
        logic [WORD_W-1:0] prefix;   // bits 0..i all free
        logic [6:0]        top;      // free run length at the high end
        logic              allfree;
    } scan_t;

endpackage

### rtl/bpa_run_scan.sv
module bpa_run_scan
    import bpa_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  logic [WORD_W-1:0] in_word,
    input  logic [WORD_W-1:0] in_mask,
    input  logic [7:0]        count,
    output scan_t             scan
);

    logic [WORD_W-1:0] f;
    logic [WORD_W-1:0] r [0:6];
    logic [WORD_W-1:0] inner;
    logic [WORD_W-1:0] prefix;
    logic [5:0]        hz;
    logic              allfree;
    scan_t             scan_reg;
    scan_t             scan_next;

    // free pages inside the searched range
    assign f       = ~in_word & in_mask;
    assign allfree = &f;

    // runs of length >= 2^k ending at each bit
    always_comb begin
        r[0] = f;
        for (int k = 1; k <= 6; k++) begin
            r[k] = r[k-1] & (r[k-1] << (1 << (k - 1)));
        end
    end

    // runs >= count inside the word, built from the power-of-two runs
    always_comb begin
        inner = '1;
        if (count == 8'd0 || count > 8'd64) begin
            inner = '0;
        end else if (count == 8'd64) begin
            inner = r[6];
        end else begin
            for (int k = 0; k < 6; k++) begin
                if (count[k]) begin
                    inner = inner & (r[k] << (count[5:0] & ~6'((2 << k) - 1)));
                end
            end
        end
    end

    // prefix all-free mask by doubling
    always_comb begin
        prefix = f;
        for (int s = 0; s < 6; s++) begin
            prefix = prefix & ((prefix << (1 << s)) | ~({WORD_W{1'b1}} << (1 << s)));
        end
    end

    // highest occupied bit, for the free run at the top of the word
    always_comb begin
        hz = '0;
        for (int i = 0; i < WORD_W; i++) begin
            if (!f[i]) begin
                hz = 6'(i);
            end
        end
    end

    always_comb begin
        scan_next.valid   = in_valid;
        scan_next.inner   = inner;
        scan_next.prefix  = prefix;
        scan_next.top     = allfree ? 7'd64 : 7'(6'd63 - hz);
        scan_next.allfree = allfree;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_reg.valid <= 1'b0;
        end else begin
            scan_reg.valid <= scan_next.valid;
        end
        scan_reg.inner   <= scan_next.inner;
        scan_reg.prefix  <= scan_next.prefix;
        scan_reg.top     <= scan_next.top;
        scan_reg.allfree <= scan_next.allfree;
    end

    assign scan = scan_reg;

endmodule

### rtl/bitmap_page_allocator_unit.sv
// Channel   | Ports             | Contents (low bit first)
// request   | s_tvalid/s_tready | tdata: alloc_count[7:0], free_address[55:8]; tuser: op
// result    | m_tvalid/m_tready | tdata: block_address[47:0], block_index[59:48]; tuser: status
// config    | cfg_we            | cfg_index 0 pool_base, 1 pages_in_use; cfg_wdata
//
// One request at a time. Allocate streams the occupancy bitmap one 64-page word per
// cycle through a two-stage scan, up to two passes (hint to end, then from page 0);
// it then read-modify-writes 1 to 5 words, writes the length and returns the result.
// Free checks the address, reads the stored length, read-modify-writes each touched
// word and clears the length. After reset a clearing sweep zeroes both memories
// before the first request is taken. A stalled result stays in the output register
// while the next request is worked on.
module bitmap_page_allocator_unit
    import bpa_pkg::*;
#(
    parameter int MAX_PAGES  = 4096,
    parameter int PAGE_SHIFT = 12
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,    // alloc_count[7:0], free_address[55:8]
    input  logic [0:0]  s_tuser,    // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,    // block_address[47:0], block_index[59:48], zero pad
    output logic [1:0]  m_tuser,    // status
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [47:0] cfg_wdata
);

    localparam int WORDS = (MAX_PAGES + WORD_W - 1) / WORD_W;
    localparam int WIW   = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int PW    = $clog2(MAX_PAGES);
    localparam int GW    = WIW + WBIT_W;
    localparam int NW    = $clog2(MAX_PAGES + 1);
    localparam int CW    = (NW > 13) ? NW : 13;
    localparam int XW    = ((CW > GW) ? CW : GW) + 1;
    localparam int PGW   = 48 - PAGE_SHIFT;
    localparam logic signed [XW-1:0] S64  = XW'(64);
    localparam logic signed [XW-1:0] SZRO = '0;

    // memories
    logic [WORD_W-1:0] bm_mem  [0:(2**WIW)-1];
    logic [7:0]        len_mem [0:MAX_PAGES-1];
    logic [WORD_W-1:0] bm_q;
    logic [7:0]        len_q;
    logic [WIW-1:0]    bm_raddr;
    logic              bm_we;
    logic [WIW-1:0]    bm_waddr;
    logic [WORD_W-1:0] bm_wdata;
    logic [PW-1:0]     len_raddr;
    logic              len_we;
    logic [PW-1:0]     len_waddr;
    logic [7:0]        len_wdata;

    state_t state_reg, state_next;

    logic            op_reg;
    logic [7:0]      count_reg;
    logic [47:0]     fa_reg;
    logic [47:0]     pool_base_reg;
    logic [12:0]     piu_reg;
    logic [PW-1:0]   hint_reg;
    logic [WIW-1:0]  iss_w_reg;
    logic            issuing_reg;
    logic            pass1_reg;
    logic            rd_valid_reg;
    logic [WIW-1:0]  rd_w_reg;
    logic [WIW-1:0]  sw_reg;
    logic [7:0]      r_reg;
    logic [GW-1:0]   rs_reg;
    logic [GW-1:0]   re_reg;
    logic [WIW-1:0]  cw_reg;
    logic [PW-1:0]   clr_cnt_reg;
    logic [1:0]      res_status_reg;
    logic [47:0]     res_addr_reg;
    logic [11:0]     res_idx_reg;
    logic            m_tvalid_reg;
    logic [1:0]      m_status_reg;
    logic [47:0]     m_addr_reg;
    logic [11:0]     m_idx_reg;

    // pool size, hint and scan limits
    logic [CW-1:0]    n;
    logic [PW-1:0]    from;
    logic [GW-1:0]    from_g;
    logic [XW-1:0]    last_g;
    logic [WIW-1:0]   last_w;
    logic [WIW-1:0]   from_w;
    logic [47:0]      abase;

    assign n      = (CW'(piu_reg) > CW'(MAX_PAGES)) ? CW'(MAX_PAGES) : CW'(piu_reg);
    assign from   = (XW'(hint_reg) < XW'(n)) ? hint_reg : '0;
    assign from_g = GW'(from);
    assign from_w = from_g[GW-1:WBIT_W];
    assign last_g = XW'(n) - XW'(1);
    assign last_w = last_g[WBIT_W +: WIW];
    assign abase  = {pool_base_reg[47:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};

    // range mask for the word coming out of the bitmap
    logic signed [XW-1:0] lim;
    logic signed [XW-1:0] lo;
    logic [WORD_W-1:0]    v_hi;
    logic [WORD_W-1:0]    v_lo;

    always_comb begin
        lim = $signed(XW'(n)) - $signed(XW'({rd_w_reg, {WBIT_W{1'b0}}}));
        lo  = $signed(XW'(from)) - $signed(XW'({rd_w_reg, {WBIT_W{1'b0}}}));
        if (lim >= S64) begin
            v_hi = '1;
        end else if (lim <= SZRO) begin
            v_hi = '0;
        end else begin
            v_hi = {WORD_W{1'b1}} >> (7'd64 - lim[6:0]);
        end
        if (!pass1_reg || lo <= SZRO) begin
            v_lo = '1;
        end else if (lo >= S64) begin
            v_lo = '0;
        end else begin
            v_lo = {WORD_W{1'b1}} << lo[5:0];
        end
    end

    scan_t scan;

    bpa_run_scan u_scan (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (rd_valid_reg),
        .in_word  (bm_q),
        .in_mask  (v_hi & v_lo),
        .count    (count_reg),
        .scan     (scan)
    );

    // run tracking across words
    logic signed [9:0]  k;
    logic [WORD_W-1:0]  thr;
    logic [WORD_W-1:0]  ends;
    logic               found;
    logic [5:0]         pos;
    logic [GW-1:0]      end_g;
    logic [GW-1:0]      start_g;
    logic [8:0]         r_sum;
    logic [7:0]         r_next;
    logic               scan_hit;
    logic               scan_last;

    always_comb begin
        k = $signed({2'b00, count_reg}) - 10'sd1 - $signed({2'b00, r_reg});
        if (k < 10'sd0) begin
            thr = '1;
        end else if (k >= 10'sd64) begin
            thr = '0;
        end else begin
            thr = {WORD_W{1'b1}} << k[5:0];
        end
        ends = scan.inner | (scan.prefix & thr);
        found = |ends;
        pos = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (ends[i]) begin
                pos = 6'(i);
            end
        end
        end_g   = {sw_reg, pos};
        start_g = end_g - GW'(count_reg) + GW'(1);
        r_sum   = {1'b0, r_reg} + 9'd64;
        if (scan.allfree) begin
            r_next = r_sum[8] ? 8'hFF : r_sum[7:0];
        end else begin
            r_next = {1'b0, scan.top};
        end
        scan_hit  = (state_reg == ST_SEARCH) && scan.valid && found;
        scan_last = (state_reg == ST_SEARCH) && scan.valid && !found && (sw_reg == last_w);
    end

    // free address checks
    logic [47:0]  off;
    logic [PGW-1:0] page;
    logic         bad_free;
    logic [GW:0]  fend;
    logic [GW-1:0] fend_c;

    always_comb begin
        off      = fa_reg - abase;
        page     = off[47:PAGE_SHIFT];
        bad_free = (fa_reg[PAGE_SHIFT-1:0] != '0) || (page >= PGW'(n));
        fend     = (GW+1)'(rs_reg) + (GW+1)'(len_q) - (GW+1)'(1);
        fend_c   = (fend > (GW+1)'(MAX_PAGES - 1)) ? GW'(MAX_PAGES - 1) : GW'(fend);
    end

    // word mask for mark and clear
    logic [WIW-1:0]    rs_w;
    logic [WIW-1:0]    re_w;
    logic [5:0]        m_lo;
    logic [5:0]        m_hi;
    logic [WORD_W-1:0] rmw_mask;

    always_comb begin
        rs_w     = rs_reg[GW-1:WBIT_W];
        re_w     = re_reg[GW-1:WBIT_W];
        m_lo     = (cw_reg == rs_w) ? rs_reg[5:0] : 6'd0;
        m_hi     = (cw_reg == re_w) ? re_reg[5:0] : 6'd63;
        rmw_mask = ({WORD_W{1'b1}} << m_lo) & ({WORD_W{1'b1}} >> (6'd63 - m_hi));
    end

    logic [47:0] alloc_addr;
    assign alloc_addr = abase + (48'(rs_reg) << PAGE_SHIFT);

    logic in_fire;
    logic out_free;
    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_cnt_reg == PW'(MAX_PAGES - 1)) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (in_fire) begin
                    if (s_tuser[0] == OP_FREE) begin
                        state_next = ST_FCHK;
                    end else if (s_tdata[7:0] == 8'd0 || n == '0) begin
                        state_next = ST_RESULT;
                    end else begin
                        state_next = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH: begin
                if (scan_hit) begin
                    state_next = ST_RMW_RD;
                end else if (scan_last && !pass1_reg) begin
                    state_next = ST_RESULT;
                end
            end
            ST_FCHK:   state_next = bad_free ? ST_RESULT : ST_FLEN;
            ST_FLEN:   state_next = (len_q == 8'd0) ? ST_RESULT : ST_RMW_RD;
            ST_RMW_RD: state_next = ST_RMW_WR;
            ST_RMW_WR: state_next = (cw_reg == re_w) ? ST_LENW : ST_RMW_RD;
            ST_LENW:   state_next = ST_RESULT;
            ST_RESULT: begin
                if (out_free) state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // memory controls
    always_comb begin
        bm_raddr  = iss_w_reg;
        bm_we     = 1'b0;
        bm_waddr  = cw_reg;
        bm_wdata  = (op_reg == OP_ALLOC) ? (bm_q | rmw_mask) : (bm_q & ~rmw_mask);
        len_raddr = page[PW-1:0];
        len_we    = 1'b0;
        len_waddr = rs_reg[PW-1:0];
        len_wdata = (op_reg == OP_ALLOC) ? count_reg : 8'd0;
        unique case (state_reg)
            ST_CLEAR: begin
                bm_we     = 1'b1;
                bm_waddr  = clr_cnt_reg[WIW-1:0];
                bm_wdata  = '0;
                len_we    = 1'b1;
                len_waddr = clr_cnt_reg;
                len_wdata = 8'd0;
            end
            ST_RMW_RD: bm_raddr = cw_reg;
            ST_RMW_WR: bm_we = 1'b1;
            ST_LENW:   len_we = 1'b1;
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (bm_we) bm_mem[bm_waddr] <= bm_wdata;
        bm_q <= bm_mem[bm_raddr];
    end

    always_ff @(posedge aclk) begin
        if (len_we) len_mem[len_waddr] <= len_wdata;
        len_q <= len_mem[len_raddr];
    end

    // control and datapath registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            pool_base_reg <= '0;
            piu_reg       <= 13'd4096;
            hint_reg      <= '0;
            issuing_reg   <= 1'b0;
            pass1_reg     <= 1'b0;
            rd_valid_reg  <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rd_valid_reg <= (state_reg == ST_SEARCH) && issuing_reg;

            if (cfg_we) begin
                if (cfg_index[0] == CFG_POOL_BASE) begin
                    pool_base_reg <= cfg_wdata;
                end else begin
                    piu_reg <= cfg_wdata[12:0];
                end
            end

            if (state_reg == ST_CLEAR) clr_cnt_reg <= clr_cnt_reg + PW'(1);

            // output valid: load on a result, drop on acceptance
            if (state_reg == ST_RESULT && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (in_fire) begin
                        issuing_reg <= 1'b1;
                        pass1_reg   <= 1'b1;
                        iss_w_reg   <= from_w;
                        r_reg       <= '0;
                        op_reg      <= s_tuser[0];
                        count_reg   <= s_tdata[7:0];
                        fa_reg      <= s_tdata[55:8];
                        res_addr_reg <= '0;
                        res_idx_reg  <= '0;
                        res_status_reg <= (s_tdata[7:0] == 8'd0) ? STAT_ZERO_CNT : STAT_NO_RUN;
                    end
                end
                ST_SEARCH: begin
                    if (scan_hit) begin
                        issuing_reg <= 1'b0;
                        rs_reg      <= start_g;
                        re_reg      <= end_g;
                        cw_reg      <= start_g[GW-1:WBIT_W];
                    end else if (scan_last && pass1_reg) begin
                        pass1_reg   <= 1'b0;
                        issuing_reg <= 1'b1;
                        iss_w_reg   <= '0;
                        r_reg       <= '0;
                    end else begin
                        if (issuing_reg) begin
                            iss_w_reg <= iss_w_reg + WIW'(1);
                            if (iss_w_reg == last_w) issuing_reg <= 1'b0;
                        end
                        if (scan.valid) r_reg <= r_next;
                    end
                end
                ST_FCHK: begin
                    res_status_reg <= STAT_BAD_FREE;
                    rs_reg         <= GW'(page[PW-1:0]);
                end
                ST_FLEN: begin
                    re_reg <= fend_c;
                    cw_reg <= rs_w;
                end
                ST_RMW_WR: begin
                    cw_reg <= cw_reg + WIW'(1);
                end
                ST_LENW: begin
                    res_status_reg <= STAT_OK;
                    res_idx_reg    <= 12'(rs_reg);
                    if (op_reg == OP_ALLOC) begin
                        hint_reg     <= rs_reg[PW-1:0];
                        res_addr_reg <= alloc_addr;
                    end
                end
                ST_RESULT: begin
                    if (out_free) begin
                        m_status_reg <= res_status_reg;
                        m_addr_reg   <= res_addr_reg;
                        m_idx_reg    <= res_idx_reg;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // sideband stage index follows the read pipeline
    always_ff @(posedge aclk) begin
        rd_w_reg <= iss_w_reg;
        sw_reg   <= rd_w_reg;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0000, m_idx_reg, m_addr_reg};
    assign m_tuser  = m_status_reg;

endmodule
